// ----- src/moving_average_adc_scaler_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the moving average ADC scaler checker
// Concurrent assertions clocked on clk, with and without reset masking.
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_ADC_SCALER_TOP_ASSERT_SVH
`define MOVING_AVERAGE_ADC_SCALER_TOP_ASSERT_SVH

// Property checked only while out of reset
`define MAVG_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Property checked at every edge, reset included
`define MAVG_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/mavg_pkg.sv -----
// ----------------------------------------------------------------------------
// Moving average ADC scaler package
// Shared widths, register indexes, constants and controller types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mavg_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int SUM_W      = 18;
	localparam int GAIN_W     = 20;
	localparam int SCALE_W    = 12;
	localparam int MV_W       = 16;
	localparam int MV_SH      = 16;
	localparam int RES_W      = 24;
	localparam int CNT_W      = 5;
	localparam int NUM_CH     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;
	localparam int RECIP_SH   = 24;
	localparam int RECIP_W    = RECIP_SH + 1;

	localparam int CH_SUPPLY = 0;
	localparam int CH_CC     = 1;
	localparam int CH_CP     = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SUPPLY_GAIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RES_SCALE   = 2'd1;

	localparam logic [GAIN_W-1:0]   GAIN_RESET  = 20'd517623;
	localparam logic [SCALE_W-1:0]  SCALE_RESET = 12'd1000;
	localparam logic [SAMPLE_W-1:0] ADC_FULL    = 12'hFFF;
	localparam logic [RES_W-1:0]    RES_MAX     = 24'hFFFFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_AVG_MUL,
		ST_AVG_FIX,
		ST_SCALE,
		ST_DIVIDE,
		ST_DONE
	} mavg_state_t;

	typedef struct packed {
		logic load;
		logic update;
		logic avg_mul;
		logic avg_fix;
		logic scale;
		logic div_step;
		logic out_load;
	} mavg_cmd_t;

	typedef struct packed {
		logic open;
		logic div_last;
	} mavg_sts_t;

endpackage

// ----- src/mavg_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mavg_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- src/mavg_ctrl.sv -----
// ----------------------------------------------------------------------------
// Moving average ADC scaler controller
// Sequences one scan through update, average, scale, divide (skipped when CC reads open) and output load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mavg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  mavg_pkg::mavg_sts_t sts,
	output mavg_pkg::mavg_cmd_t cmd
);

	import mavg_pkg::*;

	mavg_state_t state_q;
	mavg_state_t state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_AVG_MUL;
			end
			ST_AVG_MUL: begin
				cmd.avg_mul = 1'b1;
				state_d     = ST_AVG_FIX;
			end
			ST_AVG_FIX: begin
				cmd.avg_fix = 1'b1;
				state_d     = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				// skip the divider when the CC line reads open
				state_d = sts.open ? ST_DONE : ST_DIVIDE;
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// hold until the output register is free
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- src/mavg_dp.sv -----
// ----------------------------------------------------------------------------
// Moving average ADC scaler datapath
// Sample rings, running sums, reciprocal averaging, gain, serial divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mavg_dp #(
	parameter int FILTER_DEPTH = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mavg_pkg::mavg_cmd_t                 cmd,
	output mavg_pkg::mavg_sts_t                 sts,
	input  logic                                cfg_we,
	input  logic [mavg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mavg_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [mavg_pkg::SAMPLE_W-1:0]       raw_supply,
	input  logic [mavg_pkg::SAMPLE_W-1:0]       raw_cc_detect,
	input  logic [mavg_pkg::SAMPLE_W-1:0]       raw_cp_detect,
	output logic [mavg_pkg::MV_W-1:0]           supply_millivolts,
	output logic [mavg_pkg::SAMPLE_W-1:0]       cc_average,
	output logic [mavg_pkg::RES_W-1:0]          cc_resistance,
	output logic                                cc_open,
	output logic [mavg_pkg::SAMPLE_W-1:0]       cp_average
);

	import mavg_pkg::*;

	localparam int AW     = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
	localparam int DW     = $clog2(FILTER_DEPTH + 1);
	localparam int RAM_W  = NUM_CH * SAMPLE_W;
	localparam int PROD_W = SUM_W + RECIP_W;
	localparam int QD_W   = SUM_W + DW;
	localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((64'd1 << RECIP_SH) / FILTER_DEPTH);
	localparam logic [DW-1:0]      DEPTH_C = DW'(FILTER_DEPTH);
	localparam logic [AW-1:0]      POS_LAST = AW'(FILTER_DEPTH - 1);

	logic [SAMPLE_W-1:0]     sample_q [NUM_CH];
	logic [SUM_W-1:0]        sum_q    [NUM_CH];
	logic [PROD_W-1:0]       prod_s1  [NUM_CH];
	logic [SAMPLE_W-1:0]     avg_q    [NUM_CH];
	logic [SAMPLE_W-1:0]     old_smp  [NUM_CH];
	logic [SUM_W-1:0]        quo_est  [NUM_CH];
	logic [QD_W-1:0]         quo_dep  [NUM_CH];
	logic [QD_W-1:0]         quo_rem  [NUM_CH];
	logic [SUM_W-1:0]        avg_full [NUM_CH];
	logic [SAMPLE_W-1:0]     avg_sat  [NUM_CH];

	logic [AW-1:0]           pos_q;
	logic [FILTER_DEPTH-1:0] valid_q;
	logic                    valid_rd_q;
	logic [RAM_W-1:0]        wr_data;
	logic [RAM_W-1:0]        rd_data;

	logic [GAIN_W-1:0]       gain_q;
	logic [SCALE_W-1:0]      scale_q;
	logic [SAMPLE_W+GAIN_W-1:0] mv_prod;
	logic [RES_W-1:0]        num;
	logic [MV_W-1:0]         mv_q;

	logic [RES_W-1:0]        quo_q;
	logic [SAMPLE_W-1:0]     rem_q;
	logic [SAMPLE_W-1:0]     dvs_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [SAMPLE_W:0]       trial;
	logic [SAMPLE_W:0]       trial_diff;
	logic                    trial_ge;
	logic                    open_now;

	mavg_ram #(
		.WIDTH(RAM_W),
		.DEPTH(FILTER_DEPTH)
	) u_ring (
		.clk    (clk),
		.wr_en  (cmd.update),
		.wr_addr(pos_q),
		.wr_data(wr_data),
		.rd_en  (cmd.load),
		.rd_addr(pos_q),
		.rd_data(rd_data)
	);

	assign wr_data = {sample_q[CH_CP], sample_q[CH_CC], sample_q[CH_SUPPLY]};

	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			// a slot never written reads as zero, through its cleared valid flag
			old_smp[i]  = valid_rd_q ? rd_data[i*SAMPLE_W +: SAMPLE_W] : '0;
			quo_est[i]  = prod_s1[i][RECIP_SH +: SUM_W];
			quo_dep[i]  = QD_W'(quo_est[i]) * QD_W'(DEPTH_C);
			quo_rem[i]  = QD_W'(sum_q[i]) - quo_dep[i];
			// estimate is at most one low: bump it when the remainder reaches depth
			avg_full[i] = quo_est[i] + SUM_W'(quo_rem[i] >= QD_W'(DEPTH_C));
			avg_sat[i]  = (avg_full[i] > SUM_W'(ADC_FULL)) ? ADC_FULL
				: avg_full[i][SAMPLE_W-1:0];
		end
	end

	assign mv_prod    = (SAMPLE_W + GAIN_W)'(avg_q[CH_SUPPLY]) * (SAMPLE_W + GAIN_W)'(gain_q);
	assign num        = RES_W'(avg_q[CH_CC]) * RES_W'(scale_q);
	assign open_now   = (avg_q[CH_CC] == ADC_FULL);
	assign trial      = {rem_q, quo_q[RES_W-1]};
	assign trial_ge   = (trial >= {1'b0, dvs_q});
	assign trial_diff = trial - {1'b0, dvs_q};

	assign sts.open     = open_now;
	assign sts.div_last = (cnt_q == CNT_W'(RES_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			valid_q    <= '0;
			valid_rd_q <= 1'b0;
			gain_q     <= GAIN_RESET;
			scale_q    <= SCALE_RESET;
			cnt_q      <= '0;
			for (int i = 0; i < NUM_CH; i++) begin
				sum_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SUPPLY_GAIN: gain_q <= cfg_data[GAIN_W-1:0];
					REG_RES_SCALE:   scale_q <= cfg_data[SCALE_W-1:0];
					default: begin
						// drop writes to unmapped indexes
					end
				endcase
			end
			if (cmd.load) begin
				valid_rd_q <= valid_q[pos_q];
			end
			if (cmd.update) begin
				valid_q[pos_q] <= 1'b1;
				pos_q <= (pos_q == POS_LAST) ? '0 : pos_q + AW'(1);
				for (int i = 0; i < NUM_CH; i++) begin
					sum_q[i] <= sum_q[i] - SUM_W'(old_smp[i]) + SUM_W'(sample_q[i]);
				end
			end
			if (cmd.scale) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q[CH_SUPPLY] <= raw_supply;
			sample_q[CH_CC]     <= raw_cc_detect;
			sample_q[CH_CP]     <= raw_cp_detect;
		end
		if (cmd.avg_mul) begin
			for (int i = 0; i < NUM_CH; i++) begin
				prod_s1[i] <= PROD_W'(sum_q[i]) * PROD_W'(RECIP);
			end
		end
		if (cmd.avg_fix) begin
			for (int i = 0; i < NUM_CH; i++) begin
				avg_q[i] <= avg_sat[i];
			end
		end
		if (cmd.scale) begin
			mv_q  <= mv_prod[MV_SH +: MV_W];
			quo_q <= num;
			rem_q <= '0;
			dvs_q <= ADC_FULL - avg_q[CH_CC];
		end else if (cmd.div_step) begin
			// restoring step: one quotient bit per cycle
			rem_q <= trial_ge ? trial_diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
			quo_q <= {quo_q[RES_W-2:0], trial_ge};
		end
		if (cmd.out_load) begin
			supply_millivolts <= mv_q;
			cc_average        <= avg_q[CH_CC];
			cc_resistance     <= open_now ? RES_MAX : quo_q;
			cc_open           <= open_now;
			cp_average        <= avg_q[CH_CP];
		end
	end

endmodule

// ----- src/moving_average_adc_scaler_top.sv -----
// A scan steps through load, update, average multiply, average fix, scale, the
// 24-step restoring divider for the CC resistance and output load; the divider
// is skipped when CC reads open. A new scan is taken only once the last one is done.
// The output register lets the next scan be taken while a result waits.
// Reset (arst_n low) clears sums, write position and valid flags, not the ring
// RAM, and restores gain 517623 and scale 1000; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Moving average ADC scaler top level
// Boxcar average of three ADC channels with supply gain and CC resistance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module moving_average_adc_scaler_top #(
	parameter int FILTER_DEPTH = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mavg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mavg_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [mavg_pkg::SAMPLE_W-1:0]       raw_supply,
	input  logic [mavg_pkg::SAMPLE_W-1:0]       raw_cc_detect,
	input  logic [mavg_pkg::SAMPLE_W-1:0]       raw_cp_detect,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mavg_pkg::MV_W-1:0]           supply_millivolts,
	output logic [mavg_pkg::SAMPLE_W-1:0]       cc_average,
	output logic [mavg_pkg::RES_W-1:0]          cc_resistance,
	output logic                                cc_open,
	output logic [mavg_pkg::SAMPLE_W-1:0]       cp_average
);

	import mavg_pkg::*;

	mavg_cmd_t cmd;
	mavg_sts_t sts;
	logic      cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	mavg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mavg_dp #(
		.FILTER_DEPTH(FILTER_DEPTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.raw_supply       (raw_supply),
		.raw_cc_detect    (raw_cc_detect),
		.raw_cp_detect    (raw_cp_detect),
		.supply_millivolts(supply_millivolts),
		.cc_average       (cc_average),
		.cc_resistance    (cc_resistance),
		.cc_open          (cc_open),
		.cp_average       (cp_average)
	);

endmodule

// ----- src/mavg_chk.sv -----
// ----------------------------------------------------------------------------
// Moving average ADC scaler port checker
// Watches the top-level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "moving_average_adc_scaler_top_assert.svh"

module mavg_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [mavg_pkg::SAMPLE_W-1:0]  cc_average,
	input logic [mavg_pkg::RES_W-1:0]     cc_resistance,
	input logic                           cc_open
);

	import mavg_pkg::*;

	// a result beat stays up until taken
	`MAVG_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "out_valid dropped before accept")

	// one scan at a time: no beat is taken right after an accept
	`MAVG_ASSERT(a_one_scan, in_valid && in_ready |=> !in_ready, "input taken while a scan is in flight")

	// open flag and saturated resistance go together with a full-scale average
	`MAVG_ASSERT(a_open_sat, out_valid && cc_open |-> cc_resistance == RES_MAX && cc_average == ADC_FULL, "open result not saturated")

	`MAVG_ASSERT(a_open_flag, out_valid && !cc_open |-> cc_average != ADC_FULL, "full-scale CC average without open flag")

	// nothing is offered once reset has been seen at an edge
	`MAVG_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !out_valid, "out_valid high during reset")

endmodule

bind moving_average_adc_scaler_top mavg_chk u_chk (.*);
